FILE: src/hpvp_pkg.sv
// ----------------------------------------------------------------------------
// hpvp_pkg
// shared widths, fixed-point format and saturating helpers for the
// hermite position/velocity predictor
// ----------------------------------------------------------------------------
package hpvp_pkg;

  localparam int FRAC_BITS = 32;   // fractional bits of every Q format value
  localparam int DATA_W    = 64;   // signed data word
  localparam int TIME_W    = 63;   // unsigned time word
  localparam int HALF_W    = DATA_W / 2;
  localparam int MUL_LAT   = 4;    // register stages inside the fixed-point multiplier

  localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // signed add, clamped to the data range
  function automatic logic signed [DATA_W-1:0] sat_add(
    input logic signed [DATA_W-1:0] a,
    input logic signed [DATA_W-1:0] b
  );
    logic signed [DATA_W:0] sum;
    sum = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (sum[DATA_W] != sum[DATA_W-1]) begin
      sat_add = sum[DATA_W] ? SAT_MIN : SAT_MAX;
    end else begin
      sat_add = sum[DATA_W-1:0];
    end
  endfunction

  // w + floor(w/2), clamped
  function automatic logic signed [DATA_W-1:0] sat_mul15(
    input logic signed [DATA_W-1:0] w
  );
    logic signed [DATA_W-1:0] half;
    half = w >>> 1;
    sat_mul15 = sat_add(w, half);
  endfunction

endpackage

FILE: src/hpvp_if.sv
// ----------------------------------------------------------------------------
// hpvp channel interfaces
// valid/ready word channels for particle axis records and predictions
// ----------------------------------------------------------------------------
interface hpvp_in_if;
  import hpvp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [TIME_W-1:0]        start_time;
  logic [TIME_W-1:0]        prev_pred_time;
  logic signed [DATA_W-1:0] base_pos;
  logic signed [DATA_W-1:0] base_vel;
  logic signed [DATA_W-1:0] half_force;
  logic signed [DATA_W-1:0] sixth_jerk;
  logic                     last_in;

  modport source (
    output valid, start_time, prev_pred_time, base_pos, base_vel,
           half_force, sixth_jerk, last_in,
    input  ready
  );

  modport sink (
    input  valid, start_time, prev_pred_time, base_pos, base_vel,
           half_force, sixth_jerk, last_in,
    output ready
  );
endinterface

interface hpvp_out_if;
  import hpvp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] pred_pos;
  logic signed [DATA_W-1:0] pred_vel;
  logic                     updated;
  logic                     last_out;

  modport source (
    output valid, pred_pos, pred_vel, updated, last_out,
    input  ready
  );

  modport sink (
    input  valid, pred_pos, pred_vel, updated, last_out,
    output ready
  );
endinterface

FILE: src/hpvp_fx_mul.sv
// ----------------------------------------------------------------------------
// hpvp_fx_mul
// pipelined signed fixed-point multiply, floor rounding and saturation,
// four register stages, advances when en is high
// ----------------------------------------------------------------------------
module hpvp_fx_mul import hpvp_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [DATA_W-1:0] a,
  input  logic signed [DATA_W-1:0] b,
  output logic signed [DATA_W-1:0] p
);

  localparam int PW  = 2 * DATA_W;        // full product width
  localparam int PPW = DATA_W + 2;        // partial product width
  localparam int TOP = PW - (FRAC_BITS + DATA_W - 1);  // bits that must be sign copies

  // split operands: signed high half, unsigned low half
  logic signed [HALF_W:0]   al_s;
  logic signed [HALF_W:0]   bl_s;
  logic signed [HALF_W-1:0] ah_s;
  logic signed [HALF_W-1:0] bh_s;

  assign al_s = $signed({1'b0, a[HALF_W-1:0]});
  assign bl_s = $signed({1'b0, b[HALF_W-1:0]});
  assign ah_s = a[DATA_W-1:HALF_W];
  assign bh_s = b[DATA_W-1:HALF_W];

  // stage 1: partial products
  logic signed [PPW-1:0] pp_ll;
  logic signed [PPW-1:0] pp_lh;
  logic signed [PPW-1:0] pp_hl;
  logic signed [PPW-1:0] pp_hh;

  // stage 2: middle terms folded
  logic [DATA_W-1:0]        s2_ll;
  logic signed [DATA_W-1:0] s2_hh;
  logic signed [PPW-1:0]    s2_mid;

  // stage 3: full product
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] prod_next;

  // stage 4 combinational
  logic [TOP-1:0]           top_bits;
  logic signed [DATA_W-1:0] p_next;

  assign prod_next = $signed({s2_hh, s2_ll})
                   + ($signed({{(PW-PPW){s2_mid[PPW-1]}}, s2_mid}) <<< HALF_W);

  assign top_bits = prod[PW-1:FRAC_BITS+DATA_W-1];

  always_comb begin
    if (top_bits == '0 || top_bits == '1) begin
      p_next = prod[FRAC_BITS+DATA_W-1:FRAC_BITS];
    end else begin
      p_next = prod[PW-1] ? SAT_MIN : SAT_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll  <= PPW'(al_s) * PPW'(bl_s);
      pp_lh  <= PPW'(al_s) * PPW'(bh_s);
      pp_hl  <= PPW'(ah_s) * PPW'(bl_s);
      pp_hh  <= PPW'(ah_s) * PPW'(bh_s);
      s2_ll  <= pp_ll[DATA_W-1:0];
      s2_hh  <= pp_hh[DATA_W-1:0];
      s2_mid <= pp_lh + pp_hl;
      prod   <= prod_next;
      p      <= p_next;
    end
  end

endmodule

FILE: src/hermite_position_velocity_predictor_core.sv
// ----------------------------------------------------------------------------
// hermite_position_velocity_predictor_core
// third order taylor prediction of one particle axis per word, Q32.32
// ----------------------------------------------------------------------------
// usage
//   sample  : valid/ready sink of axis records (times, pos, vel, half force,
//             sixth jerk, last marker)
//   result  : valid/ready source of predictions (pos, vel, updated, last)
//   predict_time_we / predict_time_wdata : target time, write while idle
// path: a word accepted on sample passes the entry stage, three 4-stage
//   multiplies in series (s*jerk, s*a, s*b), one add stage after each of them and
//   the output register before it shows on result.valid
// throughput: one word per cycle while the skid register is empty; every stage
//   takes a new operand set each cycle, so records may stream back to back
// already current records (prev_pred_time equals the target) come out with
//   zero pos/vel and updated low, in order with the others
// reset: clears all valid bits, output and skid valid included, target time is 0
// stall: while result.ready is low the last prediction is held; one more
//   word lands in a skid register, then the whole pipe freezes and
//   sample.ready drops until the skid drains
// ----------------------------------------------------------------------------
module hermite_position_velocity_predictor_core import hpvp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              predict_time_we,
  input  logic [TIME_W-1:0] predict_time_wdata,
  hpvp_in_if.sink           sample,
  hpvp_out_if.source        result
);

  // stage numbers along the pipe
  localparam int ST_S   = 1;                  // s and current flag
  localparam int ST_P1  = ST_S + MUL_LAT;     // p1 = s*jerk
  localparam int ST_A   = ST_P1 + 1;          // a = hf + p1, 1.5*p1
  localparam int ST_C   = ST_A + 1;           // c = hf + 1.5*p1
  localparam int ST_SA  = ST_A + MUL_LAT;     // s*a
  localparam int ST_B   = ST_SA + 1;          // b = v0 + s*a
  localparam int ST_D   = ST_C + MUL_LAT;     // d = s*c
  localparam int ST_DD  = ST_D + 1;           // 2*d
  localparam int ST_VEL = ST_DD + 1;          // vel = v0 + 2d
  localparam int ST_SB  = ST_B + MUL_LAT;     // s*b
  localparam int ST_POS = ST_SB + 1;          // pos = x0 + s*b, final

  logic [TIME_W-1:0] predict_time;

  // global advance: the pipe moves unless the skid register is occupied
  logic en;

  // valid bits travel alongside the data
  logic [ST_POS:ST_S] vld;

  // side data delay lines, each tap read at a fixed stage
  logic signed [DATA_W-1:0] s_pipe  [ST_S:ST_B];
  logic signed [DATA_W-1:0] x0_pipe [ST_S:ST_SB];
  logic signed [DATA_W-1:0] v0_pipe [ST_S:ST_DD];
  logic signed [DATA_W-1:0] hf_pipe [ST_S:ST_A];
  logic                     cur_pipe  [ST_S:ST_SB];
  logic                     last_pipe [ST_S:ST_SB];
  logic signed [DATA_W-1:0] vel_pipe  [ST_VEL:ST_SB];
  logic signed [DATA_W-1:0] jk1;

  // arithmetic stage registers
  logic signed [DATA_W-1:0] p1;
  logic signed [DATA_W-1:0] a6;
  logic signed [DATA_W-1:0] h6;
  logic signed [DATA_W-1:0] c7;
  logic signed [DATA_W-1:0] sa;
  logic signed [DATA_W-1:0] b11;
  logic signed [DATA_W-1:0] sc;
  logic signed [DATA_W-1:0] dd12;
  logic signed [DATA_W-1:0] sb;
  logic signed [DATA_W-1:0] pos16;
  logic signed [DATA_W-1:0] vel16;
  logic                     upd16;
  logic                     last16;

  logic signed [DATA_W-1:0] s_next;
  logic                     cur_next;

  // output register and skid
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_pos;
  logic signed [DATA_W-1:0] out_vel;
  logic                     out_upd;
  logic                     out_last;
  logic                     skid_valid;
  logic signed [DATA_W-1:0] skid_pos;
  logic signed [DATA_W-1:0] skid_vel;
  logic                     skid_upd;
  logic                     skid_last;
  logic                     push;

  assign en           = !skid_valid;
  assign sample.ready = en;
  assign push         = en && vld[ST_POS];

  // elapsed time is exact: both times fit in 63 bits
  assign s_next   = $signed({1'b0, predict_time}) - $signed({1'b0, sample.start_time});
  assign cur_next = (sample.prev_pred_time == predict_time);

  // target time register
  always_ff @(posedge clk) begin
    if (rst) begin
      predict_time <= '0;
    end else if (predict_time_we) begin
      predict_time <= predict_time_wdata;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[ST_POS-1:ST_S], sample.valid};
    end
  end

  // multiplier chain
  hpvp_fx_mul u_mul_jk (.clk(clk), .en(en), .a(s_pipe[ST_S]), .b(jk1), .p(p1));
  hpvp_fx_mul u_mul_a  (.clk(clk), .en(en), .a(s_pipe[ST_A]), .b(a6),  .p(sa));
  hpvp_fx_mul u_mul_c  (.clk(clk), .en(en), .a(s_pipe[ST_C]), .b(c7),  .p(sc));
  hpvp_fx_mul u_mul_b  (.clk(clk), .en(en), .a(s_pipe[ST_B]), .b(b11), .p(sb));

  // data path, no reset
  always_ff @(posedge clk) begin
    if (en) begin
      // entry stage
      s_pipe[ST_S]    <= s_next;
      x0_pipe[ST_S]   <= sample.base_pos;
      v0_pipe[ST_S]   <= sample.base_vel;
      hf_pipe[ST_S]   <= sample.half_force;
      jk1             <= sample.sixth_jerk;
      cur_pipe[ST_S]  <= cur_next;
      last_pipe[ST_S] <= sample.last_in;

      for (int k = ST_S + 1; k <= ST_B; k++) s_pipe[k] <= s_pipe[k-1];
      for (int k = ST_S + 1; k <= ST_SB; k++) begin
        x0_pipe[k]   <= x0_pipe[k-1];
        cur_pipe[k]  <= cur_pipe[k-1];
        last_pipe[k] <= last_pipe[k-1];
      end
      for (int k = ST_S + 1; k <= ST_DD; k++) v0_pipe[k] <= v0_pipe[k-1];
      for (int k = ST_S + 1; k <= ST_A; k++) hf_pipe[k] <= hf_pipe[k-1];

      // position branch
      a6   <= sat_add(hf_pipe[ST_P1], p1);
      b11  <= sat_add(v0_pipe[ST_SA], sa);

      // velocity branch
      h6   <= sat_mul15(p1);
      c7   <= sat_add(hf_pipe[ST_A], h6);
      dd12 <= sat_add(sc, sc);
      vel_pipe[ST_VEL] <= sat_add(v0_pipe[ST_DD], dd12);
      for (int k = ST_VEL + 1; k <= ST_SB; k++) vel_pipe[k] <= vel_pipe[k-1];

      // final stage, current records report zeros
      pos16  <= cur_pipe[ST_SB] ? '0 : sat_add(x0_pipe[ST_SB], sb);
      vel16  <= cur_pipe[ST_SB] ? '0 : vel_pipe[ST_SB];
      upd16  <= !cur_pipe[ST_SB];
      last16 <= last_pipe[ST_SB];
    end
  end

  // output register with one-word skid, control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || result.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // output register with one-word skid, data
  always_ff @(posedge clk) begin
    if (!out_valid || result.ready) begin
      if (skid_valid) begin
        out_pos  <= skid_pos;
        out_vel  <= skid_vel;
        out_upd  <= skid_upd;
        out_last <= skid_last;
      end else begin
        out_pos  <= pos16;
        out_vel  <= vel16;
        out_upd  <= upd16;
        out_last <= last16;
      end
    end else if (push) begin
      skid_pos  <= pos16;
      skid_vel  <= vel16;
      skid_upd  <= upd16;
      skid_last <= last16;
    end
  end

  assign result.valid    = out_valid;
  assign result.pred_pos = out_pos;
  assign result.pred_vel = out_vel;
  assign result.updated  = out_upd;
  assign result.last_out = out_last;

  // skid only fills behind a held output word
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word present without an output word");

  // a held skid word is neither lost nor changed
  a_skid_kept: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !(out_valid && result.ready) |=> skid_valid && $stable(skid_pos)
      && $stable(skid_vel))
    else $error("skid word overwritten while output stalled");

  // frozen pipe keeps its valid bits
  a_pipe_frozen: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipe moved while stalled");

  // records that were already current carry zero payload
  a_not_updated_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_upd |-> out_pos == '0 && out_vel == '0)
    else $error("non-updated word with nonzero payload");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench for hermite_position_velocity_predictor_core
// streams particle axis records through the predictor with random gaps on
// both channels and checks every prediction word, in order, against a
// Q32.32 saturating model of the third order taylor step
// ----------------------------------------------------------------------------
module testbench;
  import hpvp_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 100000;
  localparam int unsigned LONG_HOLD    = 150;   // receiver hold-off, in cycles
  localparam int unsigned IDLE_PCT     = 21;
  localparam int unsigned DRAIN_CYCLES = 40;    // a bit over twice the pipe depth

  localparam logic [TIME_W-1:0]        TIME_MAX = '1;
  localparam logic signed [DATA_W-1:0] Q_ONE    = 64'sd1 << FRAC_BITS;

  // one axis record as offered on the sample channel
  typedef struct {
    logic [TIME_W-1:0]        start_time;
    logic [TIME_W-1:0]        prev_pred_time;
    logic signed [DATA_W-1:0] base_pos;
    logic signed [DATA_W-1:0] base_vel;
    logic signed [DATA_W-1:0] half_force;
    logic signed [DATA_W-1:0] sixth_jerk;
    logic                     last_in;
  } axis_rec_t;

  // one prediction word as seen on the result channel
  typedef struct {
    logic signed [DATA_W-1:0] pos;
    logic signed [DATA_W-1:0] vel;
    logic                     updated;
    logic                     last;
  } axis_pred_t;

  logic              clk;
  logic              rst;
  logic              predict_time_we;
  logic [TIME_W-1:0] predict_time_wdata;

  hpvp_in_if  sample_ch ();
  hpvp_out_if result_ch ();

  axis_rec_t   axis_records[$];    // records waiting to be offered
  axis_pred_t  expected_preds[$];  // predictions owed by the block, oldest first
  axis_rec_t   offered;            // record currently on the sample channel
  logic [TIME_W-1:0] target_time;  // our copy of predict_time
  logic        idle_on;            // random gaps on both channels
  logic        hold_req;           // ask the receiver for one long hold-off
  logic        hold_done;          // long hold-off already taken
  int unsigned hold_left;
  int unsigned cycle_count;
  int unsigned mismatches;

  hermite_position_velocity_predictor_core u_top (
    .clk                (clk),
    .rst                (rst),
    .predict_time_we    (predict_time_we),
    .predict_time_wdata (predict_time_wdata),
    .sample             (sample_ch),
    .result             (result_ch)
  );

  // ---------------------------------------------------------------- model

  // signed add clamped to the data range
  function automatic logic signed [DATA_W-1:0] q_add(
    input logic signed [DATA_W-1:0] a,
    input logic signed [DATA_W-1:0] b
  );
    logic [DATA_W:0] wide;
    wide = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (wide[DATA_W] == wide[DATA_W-1]) return wide[DATA_W-1:0];
    return wide[DATA_W] ? SAT_MIN : SAT_MAX;
  endfunction

  // full product, floor shift by the fraction width, then clamp
  function automatic logic signed [DATA_W-1:0] q_mul(
    input logic signed [DATA_W-1:0] a,
    input logic signed [DATA_W-1:0] b
  );
    logic [2*DATA_W-1:0]        full;
    logic signed [2*DATA_W-1:0] shifted;
    full    = {{DATA_W{a[DATA_W-1]}}, a} * {{DATA_W{b[DATA_W-1]}}, b};
    shifted = $signed(full) >>> FRAC_BITS;
    if (&shifted[2*DATA_W-1:DATA_W-1] || ~|shifted[2*DATA_W-1:DATA_W-1]) begin
      return shifted[DATA_W-1:0];
    end
    return shifted[2*DATA_W-1] ? SAT_MIN : SAT_MAX;
  endfunction

  // position and velocity of one axis at the target time
  function automatic axis_pred_t hermite_predict(
    input axis_rec_t         r,
    input logic [TIME_W-1:0] tgt
  );
    axis_pred_t               p;
    logic signed [DATA_W-1:0] s;
    logic signed [DATA_W-1:0] jerk_term;
    logic signed [DATA_W-1:0] acc;
    logic signed [DATA_W-1:0] vel_prod;
    p.last = r.last_in;
    // already current: nothing recomputed, values zeroed
    if (r.prev_pred_time == tgt) begin
      p.pos     = '0;
      p.vel     = '0;
      p.updated = 1'b0;
      return p;
    end
    // both times fit in 63 bits, so the 64-bit difference is exact
    s         = $signed({1'b0, tgt} - {1'b0, r.start_time});
    jerk_term = q_mul(s, r.sixth_jerk);
    acc       = q_add(r.half_force, jerk_term);
    acc       = q_add(r.base_vel, q_mul(s, acc));
    p.pos     = q_add(r.base_pos, q_mul(s, acc));
    // 1.5 * jerk term is the term plus its floor half
    vel_prod  = q_mul(s, q_add(r.half_force, q_add(jerk_term, jerk_term >>> 1)));
    p.vel     = q_add(r.base_vel, q_add(vel_prod, vel_prod));
    p.updated = 1'b1;
    return p;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic logic [TIME_W-1:0] q_time(input int unsigned n);
    return TIME_W'(n) << FRAC_BITS;
  endfunction

  // mostly moderate magnitudes so products stay in range, some raw and edge values
  function automatic logic signed [DATA_W-1:0] rand_data();
    logic signed [DATA_W-1:0] raw;
    raw = $signed({$urandom, $urandom});
    case ($urandom_range(0, 9))
      0: return raw;
      1: begin
        case ($urandom_range(0, 3))
          0:       return SAT_MAX;
          1:       return SAT_MIN;
          2:       return '0;
          default: return '1;
        endcase
      end
      default: return raw >>> $urandom_range(14, 40);
    endcase
  endfunction

  // a time close to the target most of the time, so s stays small
  function automatic logic [TIME_W-1:0] near_time(input logic [TIME_W-1:0] tgt);
    logic [TIME_W-1:0] off;
    case ($urandom_range(0, 9))
      0: return TIME_W'({$urandom, $urandom});
      1: return ($urandom_range(0, 1) == 1) ? TIME_MAX : '0;
      default: begin
        off = TIME_W'({$urandom, $urandom} >> $urandom_range(24, 62));
        if ($urandom_range(0, 1) == 1 && tgt >= off) return tgt - off;
        if (TIME_MAX - tgt >= off) return tgt + off;
        return tgt - off;
      end
    endcase
  endfunction

  function automatic axis_rec_t random_rec(input logic [TIME_W-1:0] tgt);
    axis_rec_t r;
    r.start_time     = near_time(tgt);
    r.prev_pred_time = ($urandom_range(0, 99) < 18) ? tgt : near_time(tgt);
    r.base_pos       = rand_data();
    r.base_vel       = rand_data();
    r.half_force     = rand_data();
    r.sixth_jerk     = rand_data();
    r.last_in        = ($urandom_range(0, 7) == 0);
    return r;
  endfunction

  task automatic push_rec(
    input logic [TIME_W-1:0]        st,
    input logic [TIME_W-1:0]        pp,
    input logic signed [DATA_W-1:0] x0,
    input logic signed [DATA_W-1:0] v0,
    input logic signed [DATA_W-1:0] hf,
    input logic signed [DATA_W-1:0] jk,
    input logic                     last
  );
    axis_rec_t r;
    r.start_time     = st;
    r.prev_pred_time = pp;
    r.base_pos       = x0;
    r.base_vel       = v0;
    r.half_force     = hf;
    r.sixth_jerk     = jk;
    r.last_in        = last;
    axis_records.push_back(r);
  endtask

  task automatic push_random(input int unsigned n);
    repeat (n) axis_records.push_back(random_rec(target_time));
  endtask

  // block is idle once nothing is queued, offered or owed
  task automatic wait_drained();
    while (axis_records.size() != 0 || sample_ch.valid || expected_preds.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // new target time, written only while idle
  task automatic set_target(input logic [TIME_W-1:0] t);
    wait_drained();
    @(posedge clk);
    predict_time_we    <= 1'b1;
    predict_time_wdata <= t;
    @(posedge clk);
    predict_time_we    <= 1'b0;
    target_time = t;
    @(negedge clk);
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  // ---------------------------------------------------------------- clock

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------- driver

  // offers queued records; the model runs on a word the edge it is taken
  always @(posedge clk) begin
    if (rst) begin
      sample_ch.valid          <= 1'b0;
      sample_ch.start_time     <= '0;
      sample_ch.prev_pred_time <= '0;
      sample_ch.base_pos       <= '0;
      sample_ch.base_vel       <= '0;
      sample_ch.half_force     <= '0;
      sample_ch.sixth_jerk     <= '0;
      sample_ch.last_in        <= 1'b0;
    end else begin
      if (sample_ch.valid && sample_ch.ready) begin
        expected_preds.push_back(hermite_predict(offered, target_time));
      end
      if (!sample_ch.valid || sample_ch.ready) begin
        if (axis_records.size() != 0 && !(idle_on && $urandom_range(0, 99) < IDLE_PCT)) begin
          offered = axis_records.pop_front();
          sample_ch.start_time     <= offered.start_time;
          sample_ch.prev_pred_time <= offered.prev_pred_time;
          sample_ch.base_pos       <= offered.base_pos;
          sample_ch.base_vel       <= offered.base_vel;
          sample_ch.half_force     <= offered.half_force;
          sample_ch.sixth_jerk     <= offered.sixth_jerk;
          sample_ch.last_in        <= offered.last_in;
          sample_ch.valid          <= 1'b1;
        end else begin
          sample_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  // random stalls, plus one long hold-off on request so the pipe backs up
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      hold_left       <= 0;
      hold_done       <= 1'b0;
    end else if (hold_left != 0) begin
      result_ch.ready <= 1'b0;
      hold_left       <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      result_ch.ready <= 1'b0;
      hold_left       <= LONG_HOLD;
      hold_done       <= 1'b1;
    end else begin
      result_ch.ready <= !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin : check_preds
    axis_pred_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_preds.size() == 0) begin
        report_mismatch($sformatf("prediction word with none owed, pos %h vel %h",
                                  result_ch.pred_pos, result_ch.pred_vel));
      end else begin
        want = expected_preds.pop_front();
        if (result_ch.pred_pos !== want.pos) begin
          report_mismatch($sformatf("pred_pos %h, want %h", result_ch.pred_pos, want.pos));
        end
        if (result_ch.pred_vel !== want.vel) begin
          report_mismatch($sformatf("pred_vel %h, want %h", result_ch.pred_vel, want.vel));
        end
        if (result_ch.updated !== want.updated) begin
          report_mismatch($sformatf("updated %b, want %b", result_ch.updated, want.updated));
        end
        if (result_ch.last_out !== want.last) begin
          report_mismatch($sformatf("last_out %b, want %b", result_ch.last_out, want.last));
        end
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    // controls known from time zero
    rst                      = 1'b1;
    predict_time_we          = 1'b0;
    predict_time_wdata       = '0;
    target_time              = '0;
    idle_on                  = 1'b1;
    hold_req                 = 1'b0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // target still at its reset value of zero
    push_rec('0, 1, 5 * Q_ONE, -2 * Q_ONE, Q_ONE / 2, Q_ONE / 4, 1'b0);  // s is zero
    push_rec(TIME_MAX, 5, Q_ONE, Q_ONE, Q_ONE, Q_ONE, 1'b0);          // huge negative s
    push_rec(7, '0, 9 * Q_ONE, Q_ONE, Q_ONE, Q_ONE, 1'b1);            // already current

    // target 10.0
    set_target(q_time(10));
    push_rec(q_time(8), 1, Q_ONE, 3 * Q_ONE, Q_ONE / 2, Q_ONE / 4, 1'b0);
    push_rec(q_time(12), '0, -Q_ONE, 4 * Q_ONE, -3 * Q_ONE, Q_ONE / 8, 1'b0);  // target before start
    push_rec(q_time(3), q_time(10), 4 * Q_ONE, Q_ONE, Q_ONE, Q_ONE, 1'b0);  // already current
    push_rec(q_time(8), '0, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, 1'b1);      // clamps high
    push_rec(q_time(8), '0, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, 1'b0);      // clamps low
    push_rec(q_time(10) - 1, '0, -1, -1, -1, -1, 1'b0);               // floor on one lsb of s
    push_rec(q_time(10) - (q_time(1) >> 1), 3,
             -Q_ONE / 3, -Q_ONE / 7, -Q_ONE / 5, -Q_ONE / 9, 1'b1);   // negative fractions
    push_rec('0, TIME_MAX, '0, '0, '0, '0, 1'b1);
    push_rec(q_time(9), '0, SAT_MAX - 5, Q_ONE, '0, '0, 1'b0);        // final add clamps high
    push_rec(q_time(11), '0, SAT_MIN + 5, Q_ONE, '0, '0, 1'b0);       // final add clamps low

    // target at the top of the time range
    set_target(TIME_MAX);
    push_rec('0, '0, 1, 1, 1, 1, 1'b0);                               // largest positive s
    push_rec(TIME_MAX, '0, 7 * Q_ONE, -Q_ONE, Q_ONE, -Q_ONE, 1'b1);
    push_rec('0, TIME_MAX, 3 * Q_ONE, Q_ONE, Q_ONE, Q_ONE, 1'b0);     // already current
    push_rec(TIME_MAX - q_time(1), 1,
             64'sh5555_5555_5555_5555, 64'shAAAA_AAAA_AAAA_AAAA,
             64'sh5555_5555_5555_5555, 64'shAAAA_AAAA_AAAA_AAAA, 1'b0);
    push_rec(63'h2AAA_AAAA_AAAA_AAAA, 63'h5555_5555_5555_5555,
             64'shAAAA_AAAA_AAAA_AAAA, 64'sh5555_5555_5555_5555,
             64'shAAAA_AAAA_AAAA_AAAA, 64'sh5555_5555_5555_5555, 1'b1);

    // random target, long receiver hold-off while the queue is deep
    set_target(TIME_W'({$urandom, $urandom}));
    push_random(140);
    hold_req = 1'b1;

    // zero target, no gaps at all on either side
    set_target('0);
    idle_on = 1'b0;
    push_random(140);
    wait_drained();
    idle_on = 1'b1;

    // top target, sender pauses until every prediction is back
    set_target(TIME_MAX);
    push_random(70);
    wait_drained();
    push_random(70);

    // small target, then a full random one, then one near the top
    set_target(TIME_W'($urandom));
    push_random(140);
    set_target(TIME_W'({$urandom, $urandom}));
    push_random(140);
    set_target(TIME_MAX - TIME_W'($urandom));
    push_random(140);

    // drain, then a few more cycles to catch stray words
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: hermite_position_velocity_predictor_core.f
src/hpvp_pkg.sv
src/hpvp_if.sv
src/hpvp_fx_mul.sv
src/hermite_position_velocity_predictor_core.sv
verif/testbench.sv
